>>> rtl/x64_four_level_page_walk_core_defines.svh
// Assertion macros shared by the page walk core RTL.
`ifndef X64_FOUR_LEVEL_PAGE_WALK_CORE_DEFINES_SVH
`define X64_FOUR_LEVEL_PAGE_WALK_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define PWK_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pwk assertion failed");
`define PWK_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pwk assertion failed");
`else
`define PWK_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PWK_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/pwk_pkg.sv
// Types, constants and address helpers of the page walk core.
package pwk_pkg;

	localparam int PHYS_ADDR_BITS = 48;
	localparam int VA_W = 48;
	localparam int PA_W = 48;
	localparam int DATA_W = 64;
	localparam int LVL_W = 3;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [DATA_W-1:0] FRAME_MASK =
		((64'd1 << PHYS_ADDR_BITS) - 64'd1) & ~64'h0000_0000_0000_0fff;
	localparam logic [DATA_W-1:0] PTE_RESERVED = 64'h000f_0000_0000_0000;
	localparam int PTE_PRESENT_BIT = 0;
	localparam int PTE_USER_BIT = 2;
	localparam int PTE_LARGE_BIT = 7;

	localparam logic [LVL_W-1:0] LEVEL_PT = 3'd1;
	localparam logic [LVL_W-1:0] LEVEL_PD = 3'd2;
	localparam logic [LVL_W-1:0] LEVEL_PDPT = 3'd3;
	localparam logic [LVL_W-1:0] LEVEL_TOP = 3'd4;

	typedef enum logic [2:0] {
		KIND_READ       = 3'd0,
		KIND_XLATED     = 3'd1,
		KIND_ABSENT     = 3'd2,
		KIND_SUPERVISOR = 3'd3,
		KIND_RESERVED   = 3'd4,
		KIND_TOP_LARGE  = 3'd5
	} kind_t;

	typedef enum logic {
		MODE_REQUEST = 1'b0,
		MODE_DATA    = 1'b1
	} mode_t;

	// One classified beat: for a request, data is the first entry read address.
	typedef struct packed {
		mode_t             mode;
		logic [LVL_W-1:0]  level;
		logic [VA_W-1:0]   virt_addr;
		logic              user_only;
		logic [DATA_W-1:0] data;
	} item_t;

	typedef struct packed {
		logic             busy;
		logic [LVL_W-1:0] level;
	} walk_status_t;

	function automatic logic [DATA_W-1:0] entry_addr(
		input logic [DATA_W-1:0] base,
		input logic [VA_W-1:0]   va,
		input logic [LVL_W-1:0]  level
	);
		logic [8:0] idx;
		case (level)
			LEVEL_PT:   idx = va[20:12];
			LEVEL_PD:   idx = va[29:21];
			LEVEL_PDPT: idx = va[38:30];
			default:    idx = va[47:39];
		endcase
		return (base & FRAME_MASK) + {{(DATA_W-12){1'b0}}, idx, 3'b000};
	endfunction

	function automatic logic [DATA_W-1:0] page_offset_mask(input logic [LVL_W-1:0] level);
		logic [DATA_W-1:0] m;
		case (level)
			LEVEL_PT:   m = 64'h0000_0000_0000_0fff;
			LEVEL_PD:   m = 64'h0000_0000_001f_ffff;
			LEVEL_PDPT: m = 64'h0000_0000_3fff_ffff;
			default:    m = 64'h0000_007f_ffff_ffff;
		endcase
		return m;
	endfunction

endpackage

>>> rtl/pwk_if.sv
// Request and result channel interfaces of the page walk core.
interface pwk_in_if;
	logic                          valid;
	logic                          ready;
	logic                          mode;
	logic [pwk_pkg::PA_W-1:0]      table_root;
	logic [pwk_pkg::LVL_W-1:0]     start_level;
	logic [pwk_pkg::VA_W-1:0]      virt_addr;
	logic                          user_only;
	logic [pwk_pkg::DATA_W-1:0]    entry_data;

	modport source (
		output valid, mode, table_root, start_level, virt_addr, user_only, entry_data,
		input  ready
	);
	modport sink (
		input  valid, mode, table_root, start_level, virt_addr, user_only, entry_data,
		output ready
	);
endinterface

interface pwk_out_if;
	logic                          valid;
	logic                          ready;
	logic [2:0]                    result_kind;
	logic [pwk_pkg::DATA_W-1:0]    address;
	logic [pwk_pkg::LVL_W-1:0]     walk_level;

	modport source (
		output valid, result_kind, address, walk_level,
		input  ready
	);
	modport sink (
		input  valid, result_kind, address, walk_level,
		output ready
	);
endinterface

>>> rtl/pwk_front.sv
// Front end: takes request and entry beats, normalizes level, forms first read address.
module pwk_front (
	pwk_in_if.sink                req,
	input  logic                  q_ready,
	output logic                  q_push,
	output pwk_pkg::item_t        q_item
);

	logic [pwk_pkg::LVL_W-1:0] lvl;

	always_comb begin
		// A level of zero or above four means the top level.
		if (req.start_level == 3'd0 || req.start_level > pwk_pkg::LEVEL_TOP) begin
			lvl = pwk_pkg::LEVEL_TOP;
		end else begin
			lvl = req.start_level;
		end
	end

	always_comb begin
		q_item.mode      = pwk_pkg::mode_t'(req.mode);
		q_item.level     = lvl;
		q_item.virt_addr = req.virt_addr;
		q_item.user_only = req.user_only;
		if (pwk_pkg::mode_t'(req.mode) == pwk_pkg::MODE_REQUEST) begin
			q_item.data = pwk_pkg::entry_addr(
				{{(pwk_pkg::DATA_W-pwk_pkg::PA_W){1'b0}}, req.table_root},
				req.virt_addr, lvl);
		end else begin
			q_item.data = req.entry_data;
		end
	end

	assign req.ready = q_ready;
	assign q_push    = req.valid && q_ready;

endmodule

>>> rtl/pwk_queue.sv
// Short FIFO of classified beats between front and back.
module pwk_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  pwk_pkg::item_t        push_item,
	output logic                  not_full,
	output logic                  head_valid,
	input  logic                  pop,
	output pwk_pkg::item_t        head
);

	pwk_pkg::item_t                 mem_q [pwk_pkg::QUEUE_DEPTH];
	logic [pwk_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [pwk_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [pwk_pkg::QCNT_W-1:0]     count_q;

	localparam logic [pwk_pkg::QPTR_W-1:0] LAST = pwk_pkg::QPTR_W'(pwk_pkg::QUEUE_DEPTH - 1);
	localparam logic [pwk_pkg::QCNT_W-1:0] FULL = pwk_pkg::QCNT_W'(pwk_pkg::QUEUE_DEPTH);

	assign not_full   = count_q != FULL;
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

>>> rtl/pwk_back.sv
// Back end: walk state, entry checks and the registered result beat.
module pwk_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  head_valid,
	input  pwk_pkg::item_t        head,
	output logic                  pop,
	pwk_out_if.source             rsp,
	output pwk_pkg::walk_status_t status
);

	logic                          busy_q;
	logic [pwk_pkg::LVL_W-1:0]     level_q;
	logic [pwk_pkg::VA_W-1:0]      va_q;
	logic                          user_q;
	logic                          out_valid_q;
	pwk_pkg::kind_t                out_kind_q;
	logic [pwk_pkg::DATA_W-1:0]    out_addr_q;
	logic [pwk_pkg::LVL_W-1:0]     out_level_q;

	logic                          emit;
	logic                          load_walk;
	logic                          busy_d;
	logic [pwk_pkg::LVL_W-1:0]     level_d;
	pwk_pkg::kind_t                kind;
	logic [pwk_pkg::DATA_W-1:0]    addr;
	logic [pwk_pkg::LVL_W-1:0]     res_level;
	logic [pwk_pkg::DATA_W-1:0]    pte;
	logic [pwk_pkg::DATA_W-1:0]    low;
	logic [pwk_pkg::DATA_W-1:0]    va_ext;

	assign pop    = head_valid && (!out_valid_q || rsp.ready);
	assign pte    = head.data;
	assign low    = pwk_pkg::page_offset_mask(level_q);
	assign va_ext = {{(pwk_pkg::DATA_W-pwk_pkg::VA_W){1'b0}}, va_q};

	always_comb begin
		emit      = 1'b0;
		load_walk = 1'b0;
		busy_d    = busy_q;
		level_d   = level_q;
		kind      = pwk_pkg::KIND_READ;
		addr      = '0;
		res_level = level_q;
		if (head.mode == pwk_pkg::MODE_REQUEST) begin
			// Drop a request that arrives mid-walk.
			if (!busy_q) begin
				emit      = 1'b1;
				load_walk = 1'b1;
				busy_d    = 1'b1;
				level_d   = head.level;
				addr      = head.data;
				res_level = head.level;
			end
		end else if (busy_q) begin
			emit = 1'b1;
			if (!pte[pwk_pkg::PTE_PRESENT_BIT]) begin
				busy_d = 1'b0;
				kind   = pwk_pkg::KIND_ABSENT;
				addr   = (level_q == pwk_pkg::LEVEL_PT) ? pte : '0;
			end else if (user_q && !pte[pwk_pkg::PTE_USER_BIT]) begin
				busy_d = 1'b0;
				kind   = pwk_pkg::KIND_SUPERVISOR;
			end else if ((pte & pwk_pkg::PTE_RESERVED) != '0) begin
				busy_d = 1'b0;
				kind   = pwk_pkg::KIND_RESERVED;
			end else if (level_q == pwk_pkg::LEVEL_PT || pte[pwk_pkg::PTE_LARGE_BIT]) begin
				busy_d = 1'b0;
				if (level_q == pwk_pkg::LEVEL_TOP) begin
					kind = pwk_pkg::KIND_TOP_LARGE;
				end else begin
					kind = pwk_pkg::KIND_XLATED;
					addr = (pte & pwk_pkg::FRAME_MASK & ~low) | (va_ext & low);
				end
			end else begin
				// Descend one level and read the next entry.
				level_d   = level_q - 1'b1;
				res_level = level_q - 1'b1;
				addr      = pwk_pkg::entry_addr(pte, va_q, level_q - 1'b1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			level_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q      <= busy_d;
				level_q     <= level_d;
				out_valid_q <= emit;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			out_kind_q  <= kind;
			out_addr_q  <= addr;
			out_level_q <= res_level;
		end
		if (pop && load_walk) begin
			va_q   <= head.virt_addr;
			user_q <= head.user_only;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.result_kind = out_kind_q;
	assign rsp.address     = out_addr_q;
	assign rsp.walk_level  = out_level_q;

	assign status.busy  = busy_q;
	assign status.level = level_q;

endmodule

>>> rtl/x64_four_level_page_walk_core.sv
// Four-level x86-64 page walker: one beat in per cycle while the queue has room, one
// registered result beat out. A request beat (mode 0) starts a walk and answers with
// the read address of the first table entry; each entry beat (mode 1) answers with the
// next read, the physical address of a 4kB/2MB/1GB page, or a fault. Requests during a
// walk and entry beats while idle are dropped without a result. Beats are accepted at
// up to one per cycle while the queue is not full. A beat first lands in the queue,
// and the back end takes it from the queue head into the result register, which rsp
// shows. A result that waits with rsp.ready low stalls the back end. Throughput is set
// by the back end, which retires one queued beat per cycle into the result register
// unless a result waits with rsp.ready low. A two-entry queue lets the request side
// take two more beats while a result waits to be taken.
`include "x64_four_level_page_walk_core_defines.svh"

module x64_four_level_page_walk_core (
	input  logic       clk,
	input  logic       arst_n,
	pwk_in_if.sink     req,
	pwk_out_if.source  rsp
);

	logic                  q_push;
	logic                  q_not_full;
	logic                  q_valid;
	logic                  q_pop;
	pwk_pkg::item_t        push_item;
	pwk_pkg::item_t        head;
	pwk_pkg::walk_status_t walk_st;

	pwk_front u_front (
		.req     (req),
		.q_ready (q_not_full),
		.q_push  (q_push),
		.q_item  (push_item)
	);

	pwk_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (push_item),
		.not_full   (q_not_full),
		.head_valid (q_valid),
		.pop        (q_pop),
		.head       (head)
	);

	pwk_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_valid),
		.head       (head),
		.pop        (q_pop),
		.rsp        (rsp),
		.status     (walk_st)
	);

	`PWK_ASSERT_IMP(a_rsp_level, clk, arst_n, rsp.valid,
		rsp.walk_level != 3'd0 && rsp.walk_level <= pwk_pkg::LEVEL_TOP)
	`PWK_ASSERT_IMP(a_xlated_not_top, clk, arst_n,
		rsp.valid && rsp.result_kind == pwk_pkg::KIND_XLATED,
		rsp.walk_level != pwk_pkg::LEVEL_TOP)
	`PWK_ASSERT_IMP(a_busy_level, clk, arst_n, walk_st.busy,
		walk_st.level != 3'd0 && walk_st.level <= pwk_pkg::LEVEL_TOP)
	`PWK_ASSERT_NXT(a_read_busy, clk, arst_n,
		q_pop && rsp.ready && !walk_st.busy && head.mode == pwk_pkg::MODE_REQUEST,
		walk_st.busy && rsp.valid)

endmodule
